[rtl/core/deadline_timer_table_defines.svh]
`ifndef DEADLINE_TIMER_TABLE_DEFINES_SVH
`define DEADLINE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define DTT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DTT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/tdt_pkg.sv]
`timescale 1ns / 1ps

package tdt_pkg;

   localparam int TIMER_SLOTS_DEF = 16;
   localparam int MAX_SLOT_AW = 6;
   localparam logic [31:0] WINDOW_RESET = 32'd3600000;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_INACTIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_NONE     = 2'd3;

   typedef enum logic [2:0] {
      REQ_ADD     = 3'd0,
      REQ_CANCEL  = 3'd1,
      REQ_REFRESH = 3'd2,
      REQ_RESET   = 3'd3,
      REQ_EXPIRE  = 3'd4,
      REQ_NEXT    = 3'd5
   } req_code_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_SCAN,
      S_EMIT,
      S_NEXT_FIN
   } state_type;

   typedef enum logic [1:0] {
      M_FRONT,
      M_DUE,
      M_MIN,
      M_NEXT
   } mode_type;

   typedef struct packed {
      logic [31:0] period;
      logic [63:0] deadline;
   } entry_type;

   typedef struct packed {
      logic                   en;
      logic [MAX_SLOT_AW-1:0] addr;
      entry_type              data;
   } wr_type;

endpackage

[rtl/core/tdt_slot_ram.sv]
`timescale 1ns / 1ps

module tdt_slot_ram import tdt_pkg::*; #(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
   localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
   input  logic          clock,
   input  wr_type        wr,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem_ff [TIMER_SLOTS];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/deadline_timer_table.sv]
`timescale 1ns / 1ps
// channel   | ports                                          | transfer when
// ----------+------------------------------------------------+----------------------
// request   | start, busy, req_type .. req_restart_from_now  | start && !busy
// result    | rsp_valid, rsp_status .. rsp_last              | rsp_valid (1 cycle)
// config    | csr_we, csr_wdata                              | csr_we
//
// Cancel and a full-table add answer from idle; refresh and failed reset after a read.
// Add runs one pass of the slot memory for the front check, reset adds a read and
// a write before that pass, and next runs one pass and a final state.
// Expire: one pass to mark due slots, then one pass per emitted slot. One read port sets this.
// Synchronous active-high reset; no clearing pass. Results cannot be stalled.

`include "deadline_timer_table_defines.svh"

module deadline_timer_table import tdt_pkg::*; #(
   parameter int TIMER_SLOTS = TIMER_SLOTS_DEF,
   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1,
   localparam int CW = $clog2(TIMER_SLOTS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [63:0] req_now_ms,
   input  logic [3:0]  req_slot_index,
   input  logic [31:0] req_period_ms,
   input  logic        req_repeat_flag,
   input  logic        req_restart_from_now,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_timer_slot,
   output logic        rsp_front_notice,
   output logic [63:0] rsp_time_to_next,
   output logic        rsp_last
);

   localparam logic [TIMER_SLOTS-1:0] BIT0 = TIMER_SLOTS'(1);

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   logic [2:0]  op_ff, op_in;
   logic [63:0] now_ff, now_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [31:0] per_ff, per_in;
   logic        frn_ff, frn_in;
   logic [TIMER_SLOTS-1:0] active_ff, active_in;
   logic [TIMER_SLOTS-1:0] repeat_ff, repeat_in;
   logic [TIMER_SLOTS-1:0] due_ff, due_in;
   logic        front_ff, front_in;
   logic [63:0] poll_ff, poll_in;
   logic [31:0] window_ff, window_in;
   logic        roll_ff, roll_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic        rv_ff, rv_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [IW-1:0] best_ff, best_in;
   logic        bestv_ff, bestv_in;
   logic [63:0] bestdl_ff, bestdl_in;
   logic [31:0] bestper_ff, bestper_in;
   logic        earlier_ff, earlier_in;
   logic [63:0] tgt_ff, tgt_in;
   logic [IW-1:0] sidx_ff, sidx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic        rsp_front_ff, rsp_front_in;
   logic [63:0] rsp_ttn_ff, rsp_ttn_in;
   logic        rsp_last_ff, rsp_last_in;

   wr_type        wr;
   logic [IW-1:0] raddr;
   entry_type     rdata;

   logic          accept;
   logic          ok_idx;
   logic [IW-1:0] req_idx;
   logic          free_found;
   logic [IW-1:0] free_idx;
   logic          any_active;
   logic          scan_done;
   logic          earlier_step;
   logic [TIMER_SLOTS-1:0] due_step;
   logic [TIMER_SLOTS-1:0] due_rest;
   logic          reset_go;
   logic          notice;
   logic          cand;

   tdt_slot_ram #(.TIMER_SLOTS(TIMER_SLOTS)) u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign ok_idx  = (7'(req_slot_index) < 7'(TIMER_SLOTS));
   assign req_idx = IW'(req_slot_index);
   assign any_active = |active_ff;
   assign scan_done  = rv_ff && (ridx_ff == IW'(TIMER_SLOTS - 1));
   assign due_rest   = due_ff & ~(BIT0 << best_ff);
   assign reset_go   = !((per_ff == rdata.period) && !frn_ff) && active_ff[idx_ff];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
      end
   end

   // per-entry scan step
   always_comb begin
      earlier_step = earlier_ff;
      due_step     = due_ff;
      cand         = 1'b0;
      if (rv_ff) begin
         if ((ridx_ff != sidx_ff) && active_ff[ridx_ff] &&
             ((rdata.deadline < tgt_ff) ||
              ((rdata.deadline == tgt_ff) && (ridx_ff < sidx_ff)))) begin
            earlier_step = 1'b1;
         end
         if (active_ff[ridx_ff] && (roll_ff || (rdata.deadline <= now_ff))) begin
            due_step[ridx_ff] = 1'b1;
         end
         cand = (mode_ff == M_MIN) ? due_ff[ridx_ff] : active_ff[ridx_ff];
      end
   end

   assign notice = !earlier_step && !front_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority case (req_type)
                  REQ_ADD:     state_in = free_found ? S_SCAN : S_IDLE;
                  REQ_REFRESH: state_in = (ok_idx && active_ff[req_idx]) ? S_READ : S_IDLE;
                  REQ_RESET:   state_in = ok_idx ? S_READ : S_IDLE;
                  REQ_EXPIRE,
                  REQ_NEXT:    state_in = any_active ? S_SCAN : S_IDLE;
                  default:     state_in = S_IDLE;
               endcase
            end
         end
         S_READ:   state_in = ((op_ff == REQ_RESET) && reset_go) ? S_UPDATE : S_IDLE;
         S_UPDATE: state_in = S_SCAN;
         S_SCAN: begin
            if (scan_done) begin
               unique case (mode_ff)
                  M_FRONT: state_in = S_IDLE;
                  M_DUE:   state_in = (due_step != '0) ? S_SCAN : S_IDLE;
                  M_MIN:   state_in = S_EMIT;
                  M_NEXT:  state_in = S_NEXT_FIN;
               endcase
            end
         end
         S_EMIT:     state_in = (due_rest != '0) ? S_SCAN : S_IDLE;
         S_NEXT_FIN: state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mode_in    = mode_ff;
      op_in      = op_ff;
      now_in     = now_ff;
      idx_in     = idx_ff;
      per_in     = per_ff;
      frn_in     = frn_ff;
      active_in  = active_ff;
      repeat_in  = repeat_ff;
      due_in     = due_ff;
      front_in   = front_ff;
      poll_in    = poll_ff;
      window_in  = csr_we ? csr_wdata : window_ff;
      roll_in    = roll_ff;
      scan_in    = scan_ff;
      rv_in      = 1'b0;
      ridx_in    = ridx_ff;
      best_in    = best_ff;
      bestv_in   = bestv_ff;
      bestdl_in  = bestdl_ff;
      bestper_in = bestper_ff;
      earlier_in = earlier_ff;
      tgt_in     = tgt_ff;
      sidx_in    = sidx_ff;
      wr         = '0;
      raddr      = req_idx;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_slot_in   = '0;
      rsp_front_in  = 1'b0;
      rsp_ttn_in    = '0;
      rsp_last_in   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_type;
               now_in = req_now_ms;
               idx_in = req_idx;
               per_in = req_period_ms;
               frn_in = req_restart_from_now;
               scan_in    = '0;
               bestv_in   = 1'b0;
               earlier_in = 1'b0;
               priority case (req_type)
                  REQ_ADD: begin
                     if (!free_found) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr.en   = 1'b1;
                        wr.addr = MAX_SLOT_AW'(free_idx);
                        wr.data.period   = req_period_ms;
                        wr.data.deadline = req_now_ms + 64'(req_period_ms);
                        active_in[free_idx] = 1'b1;
                        repeat_in[free_idx] = req_repeat_flag;
                        tgt_in  = req_now_ms + 64'(req_period_ms);
                        sidx_in = free_idx;
                        mode_in = M_FRONT;
                     end
                  end
                  REQ_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     if (ok_idx && active_ff[req_idx]) begin
                        active_in[req_idx] = 1'b0;
                     end else begin
                        rsp_status_in = ST_INACTIVE;
                     end
                  end
                  REQ_REFRESH: begin
                     if (!(ok_idx && active_ff[req_idx])) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INACTIVE;
                     end
                  end
                  REQ_RESET: begin
                     if (!ok_idx) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_INACTIVE;
                     end
                  end
                  REQ_EXPIRE: begin
                     if (!any_active) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NONE;
                     end else begin
                        roll_in = (req_now_ms < poll_ff) &&
                                  ((poll_ff - req_now_ms) > 64'(window_ff));
                        poll_in = req_now_ms;
                        due_in  = '0;
                        mode_in = M_DUE;
                     end
                  end
                  REQ_NEXT: begin
                     front_in = 1'b0;
                     if (!any_active) begin
                        rsp_valid_in = 1'b1;
                        rsp_ttn_in   = '1;
                     end else begin
                        mode_in = M_NEXT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            if (op_ff == REQ_REFRESH) begin
               wr.en   = 1'b1;
               wr.addr = MAX_SLOT_AW'(idx_ff);
               wr.data.period   = rdata.period;
               wr.data.deadline = now_ff + 64'(rdata.period);
               rsp_valid_in = 1'b1;
            end else if (reset_go) begin
               tgt_in = frn_ff ? now_ff : (rdata.deadline - 64'(rdata.period));
            end else begin
               rsp_valid_in = 1'b1;
               if (!((per_ff == rdata.period) && !frn_ff)) begin
                  rsp_status_in = ST_INACTIVE;
               end
            end
         end
         S_UPDATE: begin
            wr.en   = 1'b1;
            wr.addr = MAX_SLOT_AW'(idx_ff);
            wr.data.period   = per_ff;
            wr.data.deadline = tgt_ff + 64'(per_ff);
            tgt_in  = tgt_ff + 64'(per_ff);
            sidx_in = idx_ff;
            mode_in = M_FRONT;
         end
         S_SCAN: begin
            if (scan_ff < CW'(TIMER_SLOTS)) begin
               raddr   = IW'(scan_ff);
               rv_in   = 1'b1;
               ridx_in = IW'(scan_ff);
               scan_in = scan_ff + 1'b1;
            end
            earlier_in = earlier_step;
            if (mode_ff == M_DUE) begin
               due_in = due_step;
            end
            if (cand && (!bestv_ff || (rdata.deadline < bestdl_ff))) begin
               bestv_in   = 1'b1;
               best_in    = ridx_ff;
               bestdl_in  = rdata.deadline;
               bestper_in = rdata.period;
            end
            if (scan_done) begin
               unique case (mode_ff)
                  M_FRONT: begin
                     if (notice) begin
                        front_in = 1'b1;
                     end
                     rsp_valid_in = 1'b1;
                     rsp_front_in = notice;
                     rsp_slot_in  = (op_ff == REQ_ADD) ? 4'(sidx_ff) : 4'd0;
                  end
                  M_DUE: begin
                     due_in = due_step;
                     if (due_step == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NONE;
                     end else begin
                        mode_in  = M_MIN;
                        scan_in  = '0;
                        bestv_in = 1'b0;
                     end
                  end
                  M_MIN, M_NEXT: ;
               endcase
            end
         end
         S_EMIT: begin
            due_in = due_rest;
            if (repeat_ff[best_ff]) begin
               wr.en   = 1'b1;
               wr.addr = MAX_SLOT_AW'(best_ff);
               wr.data.period   = bestper_ff;
               wr.data.deadline = now_ff + 64'(bestper_ff);
            end else begin
               active_in[best_ff] = 1'b0;
            end
            rsp_valid_in = 1'b1;
            rsp_slot_in  = 4'(best_ff);
            rsp_last_in  = (due_rest == '0);
            scan_in  = '0;
            bestv_in = 1'b0;
         end
         S_NEXT_FIN: begin
            rsp_valid_in = 1'b1;
            rsp_ttn_in   = (now_ff >= bestdl_ff) ? 64'd0 : (bestdl_ff - now_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         repeat_ff    <= '0;
         due_ff       <= '0;
         front_ff     <= 1'b0;
         poll_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         repeat_ff    <= repeat_in;
         due_ff       <= due_in;
         front_ff     <= front_in;
         poll_ff      <= poll_in;
         window_ff    <= window_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      op_ff      <= op_in;
      now_ff     <= now_in;
      idx_ff     <= idx_in;
      per_ff     <= per_in;
      frn_ff     <= frn_in;
      roll_ff    <= roll_in;
      scan_ff    <= scan_in;
      ridx_ff    <= ridx_in;
      best_ff    <= best_in;
      bestv_ff   <= bestv_in;
      bestdl_ff  <= bestdl_in;
      bestper_ff <= bestper_in;
      earlier_ff <= earlier_in;
      tgt_ff     <= tgt_in;
      sidx_ff    <= sidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_ttn_ff    <= rsp_ttn_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_timer_slot   = rsp_slot_ff;
   assign rsp_front_notice = rsp_front_ff;
   assign rsp_time_to_next = rsp_ttn_ff;
   assign rsp_last         = rsp_last_ff;

   `DTT_ASSERT_IMP(a_due_active, 1'b1, (due_ff & ~active_ff) == '0, "due slot is not active")
   `DTT_ASSERT_IMP(a_emit_due, state_ff == S_EMIT, bestv_ff && due_ff[best_ff], "emit without due slot")
   `DTT_ASSERT_IMP(a_full, rsp_valid_ff && rsp_status_ff == ST_FULL, &active_ff, "full with free slot")
   `DTT_ASSERT_NXT(a_refresh_busy, accept && req_type == REQ_REFRESH && ok_idx && active_ff[req_idx], busy, "refresh did not read")
   `DTT_ASSERT_IMP(a_idle_quiet, state_ff == S_IDLE, !rv_ff, "read pending in idle")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tdt_pkg::*;

   localparam int SLOTS = 16;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 400;
   localparam logic [2:0] REQ_UNUSED_6 = 3'd6;
   localparam logic [2:0] REQ_UNUSED_7 = 3'd7;
   localparam logic [63:0] ALL_ONES = '1;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic        front;
      logic [63:0] ttn;
      logic        last;
   } timer_rsp_type;

   typedef struct {
      logic [2:0]  kind;
      logic [63:0] now;
      logic [3:0]  idx;
      logic [31:0] period;
      logic        rep;
      logic        restart_now;
      logic        typed;
      timer_rsp_type rsp;
   } stim_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_type = '0;
   logic [63:0] req_now_ms = '0;
   logic [3:0]  req_slot_index = '0;
   logic [31:0] req_period_ms = '0;
   logic        req_repeat_flag = 0;
   logic        req_restart_from_now = 0;
   logic        csr_we = 0;
   logic [31:0] csr_wdata = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_timer_slot;
   logic        rsp_front_notice;
   logic [63:0] rsp_time_to_next;
   logic        rsp_last;

   // predictor state
   logic        slot_active [SLOTS];
   logic        slot_repeat [SLOTS];
   logic        slot_written [SLOTS];
   logic [31:0] slot_period [SLOTS];
   logic [63:0] slot_deadline [SLOTS];
   logic        front_pending;
   logic [63:0] last_poll;
   logic [31:0] window_ms;

   timer_rsp_type pending_rsp[$];
   int          errors = 0;
   int          cycles = 0;
   int          items_sent = 0;
   int          rsp_checked = 0;
   int          expire_slots = 0;
   logic [63:0] clock_ms;
   stim_row_type rows[$];

   deadline_timer_table u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type), .req_now_ms(req_now_ms), .req_slot_index(req_slot_index),
      .req_period_ms(req_period_ms), .req_repeat_flag(req_repeat_flag),
      .req_restart_from_now(req_restart_from_now),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_timer_slot(rsp_timer_slot),
      .rsp_front_notice(rsp_front_notice), .rsp_time_to_next(rsp_time_to_next),
      .rsp_last(rsp_last)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("tb: done, errors");
         $finish;
      end
   end

   function automatic logic orders_first(int a, int b);
      if (slot_deadline[a] != slot_deadline[b]) return slot_deadline[a] < slot_deadline[b];
      return a < b;
   endfunction

   function automatic logic claim_front(int s);
      for (int j = 0; j < SLOTS; j++)
         if (j != s && slot_active[j] && orders_first(j, s)) return 0;
      if (front_pending) return 0;
      front_pending = 1;
      return 1;
   endfunction

   function automatic void push_rsp(logic [1:0] st, logic [3:0] sl, logic fr,
                                    logic [63:0] t, logic lst);
      timer_rsp_type r;
      r.status = st; r.slot = sl; r.front = fr; r.ttn = t; r.last = lst;
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function automatic void queue_row(stim_row_type r);
      rows.insert(rows.size(), r);
   endfunction

   function automatic void timer_table_step(logic [2:0] kind, logic [63:0] now,
         logic [3:0] idx, logic [31:0] period, logic rep, logic restart_now);
      int s;
      int best;
      int n;
      int cnt;
      int order[$];
      logic roll;
      logic due [SLOTS];
      logic [63:0] t0;
      case (kind)
         REQ_ADD: begin
            s = SLOTS;
            for (int j = SLOTS - 1; j >= 0; j--) if (!slot_active[j]) s = j;
            if (s == SLOTS) push_rsp(ST_FULL, 0, 0, 0, 1);
            else begin
               slot_active[s] = 1; slot_repeat[s] = rep; slot_written[s] = 1;
               slot_period[s] = period; slot_deadline[s] = now + 64'(period);
               push_rsp(ST_OK, 4'(s), claim_front(s), 0, 1);
            end
         end
         REQ_CANCEL: begin
            if (!slot_active[idx]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
            else begin
               slot_active[idx] = 0;
               push_rsp(ST_OK, 0, 0, 0, 1);
            end
         end
         REQ_REFRESH: begin
            if (!slot_active[idx]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
            else begin
               slot_deadline[idx] = now + 64'(slot_period[idx]);
               push_rsp(ST_OK, 0, 0, 0, 1);
            end
         end
         REQ_RESET: begin
            if (period == slot_period[idx] && !restart_now) push_rsp(ST_OK, 0, 0, 0, 1);
            else if (!slot_active[idx]) push_rsp(ST_INACTIVE, 0, 0, 0, 1);
            else begin
               t0 = restart_now ? now : slot_deadline[idx] - 64'(slot_period[idx]);
               slot_period[idx] = period;
               slot_deadline[idx] = t0 + 64'(period);
               push_rsp(ST_OK, 0, claim_front(idx), 0, 1);
            end
         end
         REQ_EXPIRE: begin
            cnt = 0;
            for (int j = 0; j < SLOTS; j++) if (slot_active[j]) cnt++;
            if (cnt == 0) push_rsp(ST_NONE, 0, 0, 0, 1);
            else begin
               roll = now < last_poll && last_poll - now > 64'(window_ms);
               last_poll = now;
               for (int j = 0; j < SLOTS; j++)
                  due[j] = slot_active[j] && (roll || slot_deadline[j] <= now);
               forever begin
                  best = SLOTS;
                  for (int j = 0; j < SLOTS; j++)
                     if (due[j] && (best == SLOTS || orders_first(j, best))) best = j;
                  if (best == SLOTS) break;
                  due[best] = 0;
                  order.insert(order.size(), best);
               end
               n = order.size();
               if (n == 0) push_rsp(ST_NONE, 0, 0, 0, 1);
               for (int j = 0; j < n; j++) begin
                  s = order[j];
                  if (slot_repeat[s]) slot_deadline[s] = now + 64'(slot_period[s]);
                  else slot_active[s] = 0;
                  push_rsp(ST_OK, 4'(s), 0, 0, j == n - 1);
               end
               expire_slots += n;
            end
         end
         REQ_NEXT: begin
            front_pending = 0;
            best = SLOTS;
            for (int j = 0; j < SLOTS; j++)
               if (slot_active[j] && (best == SLOTS || orders_first(j, best))) best = j;
            if (best == SLOTS) t0 = ALL_ONES;
            else if (now >= slot_deadline[best]) t0 = 0;
            else t0 = slot_deadline[best] - now;
            push_rsp(ST_OK, 0, 0, t0, 1);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      timer_rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t unexpected result: status %0d slot %0d", $time, rsp_status,
                     rsp_timer_slot);
         end else begin
            e = pending_rsp.pop_front();
            rsp_checked++;
            if (rsp_status !== e.status || rsp_timer_slot !== e.slot ||
                rsp_front_notice !== e.front || rsp_time_to_next !== e.ttn ||
                rsp_last !== e.last) begin
               errors++;
               $display("%0t mismatch exp st=%0d slot=%0d fr=%0d ttn=%h last=%0d",
                        $time, e.status, e.slot, e.front, e.ttn, e.last);
               $display("%0t          got st=%0d slot=%0d fr=%0d ttn=%h last=%0d",
                        $time, rsp_status, rsp_timer_slot, rsp_front_notice,
                        rsp_time_to_next, rsp_last);
            end
         end
      end
   end

   task automatic send(stim_row_type r);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_type <= r.kind;
      req_now_ms <= r.now;
      req_slot_index <= r.idx;
      req_period_ms <= r.period;
      req_repeat_flag <= r.rep;
      req_restart_from_now <= r.restart_now;
      do @(posedge clock); while (busy);
      timer_table_step(r.kind, r.now, r.idx, r.period, r.rep, r.restart_now);
      if (r.typed) begin
         pending_rsp[$] = r.rsp;
         pending_rsp[$].last = 1;
      end
      items_sent++;
   endtask

   task automatic write_window(logic [31:0] value);
      start <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      window_ms = value;
   endtask

   function automatic stim_row_type row(logic [2:0] k, logic [63:0] now, logic [3:0] idx,
         logic [31:0] per, logic rep, logic fn, logic typed = 0,
         logic [1:0] st = ST_OK, logic [3:0] sl = 0, logic fr = 0, logic [63:0] t = 0);
      stim_row_type r;
      r.kind = k; r.now = now; r.idx = idx; r.period = per; r.rep = rep;
      r.restart_now = fn; r.typed = typed;
      r.rsp.status = st; r.rsp.slot = sl; r.rsp.front = fr; r.rsp.ttn = t; r.rsp.last = 1;
      return r;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.idx = 4'($urandom_range(0, 15));
      r.rep = 1'($urandom_range(0, 1));
      r.restart_now = 1'($urandom_range(0, 1));
      r.period = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 300);
      r.typed = 0;
      if (pick < 30) r.kind = REQ_ADD;
      else if (pick < 40) r.kind = REQ_CANCEL;
      else if (pick < 50) r.kind = REQ_REFRESH;
      else if (pick < 62) r.kind = REQ_RESET;
      else if (pick < 85) r.kind = REQ_EXPIRE;
      else if (pick < 97) r.kind = REQ_NEXT;
      else r.kind = pick[0] ? REQ_UNUSED_6 : REQ_UNUSED_7;
      // the period of a never-written slot must not be read
      if (r.kind == REQ_RESET && !slot_written[r.idx]) r.restart_now = 1;
      if (r.kind == REQ_RESET && $urandom_range(0, 3) == 0 && slot_written[r.idx]) begin
         r.period = slot_period[r.idx];
         r.restart_now = 0;
      end
      pick = $urandom_range(0, 49);
      if (pick == 0) clock_ms = {$urandom, $urandom};
      else if (pick < 3) clock_ms = clock_ms - 64'($urandom_range(0, 5000));
      else clock_ms = clock_ms + 64'($urandom_range(0, 150));
      r.now = clock_ms;
      return r;
   endfunction

   initial begin
      stim_row_type r;
      for (int j = 0; j < SLOTS; j++) begin
         slot_active[j] = 0; slot_repeat[j] = 0; slot_written[j] = 0;
         slot_period[j] = 0; slot_deadline[j] = 0;
      end
      front_pending = 0;
      last_poll = 0;
      window_ms = WINDOW_RESET;
      repeat (6) @(posedge clock);
      reset <= 0;

      queue_row(row(REQ_NEXT, 0, 0, 0, 0, 0, 1, ST_OK, 0, 0, ALL_ONES));
      queue_row(row(REQ_EXPIRE, 0, 0, 0, 0, 0, 1, ST_NONE));
      queue_row(row(REQ_CANCEL, 0, 0, 0, 0, 0, 1, ST_INACTIVE));
      queue_row(row(REQ_REFRESH, 0, 15, 0, 0, 0, 1, ST_INACTIVE));
      queue_row(row(REQ_RESET, 0, 3, 5, 0, 1, 1, ST_INACTIVE));
      queue_row(row(REQ_ADD, 100, 0, 50, 0, 0, 1, ST_OK, 0, 1));
      queue_row(row(REQ_ADD, 100, 9, 32'hffffffff, 1, 0));
      queue_row(row(REQ_ADD, ALL_ONES, 0, 32'hffffffff, 1, 1));
      queue_row(row(REQ_NEXT, 120, 0, 0, 0, 0));
      queue_row(row(REQ_RESET, 130, 0, 50, 1, 0, 1, ST_OK));
      queue_row(row(REQ_RESET, 130, 0, 10, 0, 0));
      queue_row(row(REQ_RESET, 130, 1, 7, 0, 1));
      queue_row(row(REQ_REFRESH, 0, 2, 0, 0, 0));
      queue_row(row(REQ_ADD, 137, 0, 0, 0, 0));
      queue_row(row(REQ_NEXT, 200, 0, 0, 0, 0));
      queue_row(row(REQ_EXPIRE, 200, 0, 0, 0, 0));
      queue_row(row(REQ_UNUSED_6, 5, 1, 1, 1, 1));
      queue_row(row(REQ_UNUSED_7, 5, 1, 1, 1, 1));
      queue_row(row(REQ_CANCEL, 0, 1, 0, 0, 0));
      queue_row(row(REQ_EXPIRE, 0, 0, 0, 0, 0));
      foreach (rows[i]) send(rows[i]);

      // fill the table, overflow it, then force a rollover of everything
      for (int j = 0; j < SLOTS; j++)
         send(row(REQ_ADD, 64'(j * 3), 0, 32'(40 - j), 1'(j % 2), 0));
      send(row(REQ_ADD, 0, 0, 1, 0, 0, 1, ST_FULL));
      send(row(REQ_EXPIRE, 64'd10000000, 0, 0, 0, 0));
      send(row(REQ_EXPIRE, 0, 0, 0, 0, 0));

      clock_ms = 1000;
      for (int i = 0; i < 500; i++) begin
         if (i == 0) write_window(0);
         else if (i == 150) write_window(32'hffffffff);
         else if (i == 300) write_window($urandom);
         else if (i == 420) write_window(WINDOW_RESET);
         send(random_row());
      end
      start <= 0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transfers in, %0d results checked, %0d expired slots",
               items_sent, rsp_checked, expire_slots);
      $display("window settings: reset value, 0, all ones, random");
      if (errors == 0) $display("tb: done, clean");
      else $display("tb: done, errors");
      $finish;
   end

endmodule
